// ===== sv/pmc_pkg.sv =====
// ============================================================================
// pmc_pkg
// Shared types, widths and helper functions for the point set mean and
// covariance core.
// ============================================================================
package pmc_pkg;

    localparam int COORD_W    = 16;
    localparam int COL_W      = 8;
    localparam int CSUM_W     = 24;
    localparam int CPROD_W    = 40;
    localparam int LSUM_W     = 16;
    localparam int LPROD_W    = 25;
    localparam int CNT_W      = 9;
    localparam int MAX_POINTS = 256;
    localparam int NUM_W      = 50;
    localparam int DVD_W      = 50;
    localparam int DVS_W      = 17;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 248;
    localparam int ELEM_W     = 4;
    localparam int LAST_ELEM  = 8;
    localparam int NUM_MEANS  = 3;

    localparam logic signed [DVD_W:0] MEAN_MAX = 51'sd32767;
    localparam logic signed [DVD_W:0] MEAN_MIN = -51'sd32768;
    localparam logic signed [DVD_W:0] COV_MAX  = 51'sd1073741824;
    localparam logic signed [DVD_W:0] COV_MIN  = -51'sd1073741824;

    typedef enum logic [1:0] {
        KIND_GEOM   = 2'd0,
        KIND_COLOUR = 2'd1,
        KIND_EMPTY  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_DRAIN,
        ST_WAIT_OUT,
        ST_NN,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_MUL,
        ST_SUB,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_STORE,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic              acc_en;
        logic              calc_nn;
        logic              fetch_a;
        logic              fetch_b;
        logic              load_mul;
        logic              load_sub;
        logic              div_start;
        logic              store;
        logic              publish;
        logic              set;
        logic [ELEM_W-1:0] elem;
    } ctrl_cmd_t;

    typedef struct packed {
        logic end_accept;
        logic out_empty;
        logic count_zero;
        logic div_done;
    } dp_status_t;

    // First and second component of each distinct covariance entry.
    function automatic logic [1:0] pair_a(input logic [2:0] k);
        logic [1:0] r;
        unique case (k)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_b(input logic [2:0] k);
        logic [1:0] r;
        unique case (k)
            3'd0:       r = 2'd0;
            3'd1, 3'd3: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/point_set_mean_covariance_core.sv =====
// ============================================================================
// point_set_mean_covariance_core
// Per-cell mean and 3x3 population covariance of point positions and colors.
// ============================================================================
// Usage:
// Points enter on the s_axis channel, one word per point, tlast on the final
// point of a cell. A point whose x, y and z are all zero is skipped, and at
// most 256 valid points per cell are counted. Points are taken at one per
// cycle while the core is accumulating; each feeds six product lanes whose
// registered results are added in the next cycle. When the final point of a
// cell is accepted, the core stops taking points, lets the pipeline drain and
// computes 18 statistics one after another on a shared radix-2 divider. It
// then publishes two words on m_axis: the geometry statistics (tuser 0) and
// the color statistics (tuser 1, tlast set). A cell without valid points
// gives a single word of kind 2 with tlast. Published words sit in a result
// buffer; the core goes on taking points of the next cell while the receiver
// stalls, and only the next cell end waits until that buffer is empty. Reset
// clears all sums, the count and any pending words.
// ============================================================================
module point_set_mean_covariance_core
    import pmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32], red[55:48], green[63:56],
    // blue[71:64]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,   // cell_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // mean_a[15:0], mean_b[31:16], mean_c[47:32], cov_00[78:48],
    // cov_01[110:79], cov_02[142:111], cov_11[173:143], cov_12[205:174],
    // cov_22[236:206], point_count[245:237], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser,   // result_kind
    output logic                  m_axis_tlast    // run_end
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pmc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    pmc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/pmc_ctrl.sv =====
// ============================================================================
// pmc_ctrl
// Sequencer: accumulation, drain, and the per-statistic finalize steps.
// ============================================================================
module pmc_ctrl
    import pmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic              set_reg, set_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            set_reg   <= 1'b0;
            elem_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            set_reg   <= set_next;
            elem_reg  <= elem_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        set_next   = set_reg;
        elem_next  = elem_reg;
        unique case (state_reg)
            ST_ACC:       if (status.end_accept) state_next = ST_DRAIN;
            ST_DRAIN:     state_next = ST_WAIT_OUT;
            ST_WAIT_OUT:
            begin
                if (status.out_empty)
                begin
                    state_next = status.count_zero ? ST_PUBLISH : ST_NN;
                end
            end
            ST_NN:
            begin
                state_next = ST_FETCH_A;
                set_next   = 1'b0;
                elem_next  = '0;
            end
            ST_FETCH_A:   state_next = ST_FETCH_B;
            ST_FETCH_B:   state_next = ST_MUL;
            ST_MUL:       state_next = ST_SUB;
            ST_SUB:       state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (status.div_done) state_next = ST_STORE;
            ST_STORE:
            begin
                if (elem_reg == ELEM_W'(LAST_ELEM))
                begin
                    elem_next = '0;
                    if (set_reg)
                    begin
                        state_next = ST_PUBLISH;
                    end
                    else
                    begin
                        set_next   = 1'b1;
                        state_next = ST_FETCH_A;
                    end
                end
                else
                begin
                    elem_next  = elem_reg + ELEM_W'(1);
                    state_next = ST_FETCH_A;
                end
            end
            ST_PUBLISH:   state_next = ST_ACC;
            default:      state_next = ST_ACC;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.set       = set_reg;
        cmd.elem      = elem_reg;
        cmd.acc_en    = (state_reg == ST_ACC);
        cmd.calc_nn   = (state_reg == ST_NN);
        cmd.fetch_a   = (state_reg == ST_FETCH_A);
        cmd.fetch_b   = (state_reg == ST_FETCH_B);
        cmd.load_mul  = (state_reg == ST_MUL);
        cmd.load_sub  = (state_reg == ST_SUB);
        cmd.div_start = (state_reg == ST_DIV_START);
        cmd.store     = (state_reg == ST_STORE);
        cmd.publish   = (state_reg == ST_PUBLISH);
    end

endmodule

// ===== sv/pmc_div.sv =====
// ============================================================================
// pmc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
module pmc_div
    import pmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DVD_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DVD_W-1:0]    quo_reg;
    logic [DVS_W-1:0]    rem_reg;
    logic [DVS_W-1:0]    dvs_reg;
    logic [DVS_W:0]      rem_shift;
    logic [DVS_W+1:0]    diff;
    logic                ge;

    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign ge        = !diff[DVS_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/pmc_dp.sv =====
// ============================================================================
// pmc_dp
// Datapath: product lanes, accumulators, finalize arithmetic, result buffer.
// ============================================================================
module pmc_dp
    import pmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    // ---------------- input stage ----------------
    logic signed [COORD_W-1:0] px [3];
    logic        [COL_W-1:0]   pc [3];
    logic                      in_acc;
    logic                      point_ok;
    logic [CNT_W-1:0]          count_reg;

    assign px[0] = s_axis_tdata[15:0];
    assign px[1] = s_axis_tdata[31:16];
    assign px[2] = s_axis_tdata[47:32];
    assign pc[0] = s_axis_tdata[55:48];
    assign pc[1] = s_axis_tdata[63:56];
    assign pc[2] = s_axis_tdata[71:64];

    assign s_axis_tready = cmd.acc_en;
    assign in_acc        = s_axis_tvalid && cmd.acc_en;
    assign point_ok      = (|{px[0], px[1], px[2]}) && (count_reg < CNT_W'(MAX_POINTS));

    logic                            s1_valid_reg;
    logic signed [COORD_W-1:0]       s1_p_reg [3];
    logic        [COL_W-1:0]         s1_c_reg [3];
    logic signed [2*COORD_W-1:0]     s1_pp_reg [6];
    logic        [2*COL_W-1:0]       s1_cp_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= in_acc && point_ok;
            if (cmd.publish)
            begin
                count_reg <= '0;
            end
            else if (in_acc && point_ok)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // One position and one color multiplier per product lane, registered before accumulation.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
        begin
            s1_pp_reg[k] <= px[pair_a(3'(k))] * px[pair_b(3'(k))];
            s1_cp_reg[k] <= pc[pair_a(3'(k))] * pc[pair_b(3'(k))];
        end
        for (int i = 0; i < 3; i++)
        begin
            s1_p_reg[i] <= px[i];
            s1_c_reg[i] <= pc[i];
        end
    end

    // ---------------- accumulators ----------------
    logic signed [CSUM_W-1:0]  csum_reg [3];
    logic signed [CPROD_W-1:0] cprod_reg [6];
    logic        [LSUM_W-1:0]  lsum_reg [3];
    logic        [LPROD_W-1:0] lprod_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                csum_reg[i] <= '0;
                lsum_reg[i] <= '0;
            end
            for (int k = 0; k < 6; k++)
            begin
                cprod_reg[k] <= '0;
                lprod_reg[k] <= '0;
            end
        end
        else if (cmd.publish)
        begin
            for (int i = 0; i < 3; i++)
            begin
                csum_reg[i] <= '0;
                lsum_reg[i] <= '0;
            end
            for (int k = 0; k < 6; k++)
            begin
                cprod_reg[k] <= '0;
                lprod_reg[k] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                csum_reg[i] <= csum_reg[i] + CSUM_W'(s1_p_reg[i]);
                lsum_reg[i] <= lsum_reg[i] + LSUM_W'(s1_c_reg[i]);
            end
            for (int k = 0; k < 6; k++)
            begin
                cprod_reg[k] <= cprod_reg[k] + CPROD_W'(s1_pp_reg[k]);
                lprod_reg[k] <= lprod_reg[k] + LPROD_W'(s1_cp_reg[k]);
            end
        end
    end

    // ---------------- finalize arithmetic ----------------
    logic              is_mean;
    logic [2:0]        cov_k;
    logic [1:0]        fetch_idx;
    logic signed [CSUM_W-1:0]  sum_sel;
    logic signed [CPROD_W-1:0] prod_sel;
    logic signed [CSUM_W-1:0]  op_a_reg, op_b_reg;
    logic signed [CPROD_W-1:0] op_p_reg;
    logic        [DVS_W-1:0]   nn_reg;
    logic signed [NUM_W-1:0]   mul_a_reg, mul_b_reg, num_reg;
    logic                      neg_reg;

    assign is_mean   = (cmd.elem < ELEM_W'(NUM_MEANS));
    assign cov_k     = 3'(cmd.elem - ELEM_W'(NUM_MEANS));
    assign fetch_idx = is_mean ? cmd.elem[1:0] : (cmd.fetch_a ? pair_a(cov_k) : pair_b(cov_k));

    always_comb
    begin
        if (cmd.set)
        begin
            sum_sel  = CSUM_W'({1'b0, lsum_reg[fetch_idx]});
            prod_sel = CPROD_W'({1'b0, lprod_reg[cov_k]});
        end
        else
        begin
            sum_sel  = csum_reg[fetch_idx];
            prod_sel = cprod_reg[cov_k];
        end
    end

    logic [DVD_W-1:0]        div_mag;
    logic [DVS_W-1:0]        div_dvs;
    logic                    div_busy, div_done;
    logic [DVD_W-1:0]        div_q;
    logic signed [DVD_W:0]   q_s;
    logic signed [DVD_W:0]   q_clamp;
    logic signed [DVD_W:0]   lo_lim, hi_lim;

    always_ff @(posedge clk)
    begin
        if (cmd.calc_nn)
        begin
            nn_reg <= DVS_W'(count_reg * count_reg);
        end
        if (cmd.fetch_a)
        begin
            op_a_reg <= sum_sel;
        end
        if (cmd.fetch_b)
        begin
            op_b_reg <= sum_sel;
            op_p_reg <= prod_sel;
        end
        if (cmd.load_mul)
        begin
            mul_a_reg <= NUM_W'($signed({1'b0, count_reg}) * op_p_reg);
            mul_b_reg <= NUM_W'(op_a_reg * op_b_reg);
        end
        if (cmd.load_sub)
        begin
            num_reg <= is_mean ? NUM_W'(op_a_reg) : (mul_a_reg - mul_b_reg);
        end
        if (cmd.div_start)
        begin
            neg_reg <= num_reg[NUM_W-1];
        end
    end

    assign div_mag = num_reg[NUM_W-1] ? DVD_W'(-num_reg) : DVD_W'(num_reg);
    assign div_dvs = is_mean ? DVS_W'(count_reg) : nn_reg;

    pmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_mag),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_s = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    always_comb
    begin
        if (is_mean)
        begin
            lo_lim = MEAN_MIN;
            hi_lim = MEAN_MAX;
        end
        else if (pair_a(cov_k) == pair_b(cov_k))
        begin
            lo_lim = '0;
            hi_lim = COV_MAX;
        end
        else
        begin
            lo_lim = COV_MIN;
            hi_lim = COV_MAX;
        end
        priority if (q_s < lo_lim) q_clamp = lo_lim;
        else if (q_s > hi_lim)     q_clamp = hi_lim;
        else                       q_clamp = q_s;
    end

    // ---------------- result buffer ----------------
    logic [COORD_W-1:0] mean_reg [2][3];
    logic [31:0]        cov_reg  [2][6];
    logic [CNT_W-1:0]   out_n_reg;
    logic [1:0]         out_cnt_reg;
    logic               out_sel_reg;
    logic               out_empty_reg;
    logic               out_acc;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            if (is_mean)
            begin
                mean_reg[cmd.set][cmd.elem[1:0]] <= q_clamp[COORD_W-1:0];
            end
            else
            begin
                cov_reg[cmd.set][cov_k] <= q_clamp[31:0];
            end
        end
        if (cmd.publish)
        begin
            out_n_reg <= count_reg;
        end
    end

    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg   <= '0;
            out_sel_reg   <= 1'b0;
            out_empty_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_cnt_reg   <= (count_reg == '0) ? 2'd1 : 2'd2;
            out_empty_reg <= (count_reg == '0);
            out_sel_reg   <= 1'b0;
        end
        else if (out_acc)
        begin
            out_cnt_reg <= out_cnt_reg - 2'd1;
            out_sel_reg <= 1'b1;
        end
    end

    logic [COORD_W-1:0] om [3];
    logic [31:0]        oc [6];
    logic [CNT_W-1:0]   on;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            om[i] = out_empty_reg ? '0 : mean_reg[out_sel_reg][i];
        end
        for (int k = 0; k < 6; k++)
        begin
            oc[k] = out_empty_reg ? '0 : cov_reg[out_sel_reg][k];
        end
        on = out_empty_reg ? '0 : out_n_reg;
    end

    assign m_axis_tvalid = (out_cnt_reg != 2'd0);
    assign m_axis_tlast  = (out_cnt_reg == 2'd1);
    assign m_axis_tuser  = out_empty_reg ? KIND_EMPTY : (out_sel_reg ? KIND_COLOUR : KIND_GEOM);
    assign m_axis_tdata  = {2'b00, on, oc[5][30:0], oc[4], oc[3][30:0], oc[2], oc[1],
                            oc[0][30:0], om[2], om[1], om[0]};

    assign status.end_accept = in_acc && s_axis_tlast;
    assign status.out_empty  = (out_cnt_reg == 2'd0);
    assign status.count_zero = (count_reg == '0);
    assign status.div_done   = div_done;

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond its limit");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> out_cnt_reg == 2'd0)
        else $error("results published over pending words");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_axis_tlast && !cmd.publish) |=> out_cnt_reg == 2'd0)
        else $error("result buffer not empty after final word");

endmodule
